### sv/xkbc_pkg.sv
package xkbc_pkg;

   typedef logic [63:0] word_type;
   typedef logic [7:0]  byte_type;
   typedef logic [2:0]  pos_type;

   // keystream mixing constants
   localparam word_type MixMult = 64'h2545_F491_4F6C_DD1D;
   localparam int unsigned ShiftA = 12;
   localparam int unsigned ShiftB = 25;
   localparam int unsigned ShiftC = 27;

   // register port: one 64-bit register per 8-byte slot
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 64;
   localparam logic        CsrIdxKey    = 1'b0;

   function automatic word_type xorshift(input word_type w);
      word_type x;
      x = w;
      x = x ^ (x >> ShiftA);
      x = x ^ (x << ShiftB);
      x = x ^ (x >> ShiftC);
      return x;
   endfunction

endpackage

### sv/xkbc_if.sv
interface xkbc_req_if;
   import xkbc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     first_of_buffer;

   modport source (output valid, output data_byte, output first_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input first_of_buffer, output ready);
endinterface

interface xkbc_rsp_if;
   import xkbc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type result_byte;

   modport source (output valid, output result_byte, input ready);
   modport sink   (input valid, input result_byte, output ready);
endinterface

### sv/xorshift_keystream_byte_cipher_unit.sv
// Byte stream cipher: every request beat carries one byte, every response beat
// returns it XORed with one byte of a 64-bit keystream word, in order, one
// response per request. A beat with first_of_buffer set reloads the word from
// the key register (64 bits at address 0) and restarts at byte 0; every eighth
// byte the word is advanced by xorshift(12,25,27) and a multiply by
// 0x2545F4914F6CDD1D, bytes taken least significant first. One beat per cycle
// is accepted sustained while rsp.ready does not stall the output; a byte passes
// from request to response through the input register, xorshift plus split 32-bit
// partial products, and final add and XOR into the output register. Write the key only with the pipe empty.
module xorshift_keystream_byte_cipher_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   xkbc_req_if.sink                               req,
   xkbc_rsp_if.source                             rsp,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [xkbc_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [xkbc_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [xkbc_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import xkbc_pkg::*;

   word_type cipher_key;
   word_type mix_word;

   // entry side
   pos_type  pos_ff, pos_in;
   pos_type  cur_pos;
   logic     req_fire;

   // stage 1: captured beat plus the word to be advanced
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_data_ff;
   pos_type  s1_pos_ff;
   logic     s1_adv_ff;
   word_type s1_base_ff;

   // stage 2: partial products held in the mixer
   logic     s2_valid_ff, s2_valid_in;
   byte_type s2_data_ff;
   pos_type  s2_pos_ff;
   logic     s2_adv_ff;

   // stage 3: output register
   logic     s3_valid_ff, s3_valid_in;
   byte_type s3_result_ff, s3_result_in;

   // committed keystream word, updated as an advancing beat leaves stage 2
   word_type word_ff, word_in;

   logic     ready1, ready2, ready3;
   byte_type ks_byte;

   xkbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cipher_key  (cipher_key)
   );

   xkbc_mix u_mix (
      .clock     (clock),
      .load      (ready2),
      .base_word (s1_base_ff),
      .next_word (mix_word)
   );

   // stall chain, combinational from rsp.ready all the way back to req.ready
   assign ready3    = !s3_valid_ff || rsp.ready;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req.ready = ready1;
   assign req_fire  = req.valid && ready1;

   // byte position at entry; a first beat restarts at zero
   assign cur_pos = req.first_of_buffer ? '0 : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         pos_in = cur_pos + pos_type'(1);
      end
   end

   assign s1_valid_in = ready1 ? req.valid : s1_valid_ff;
   assign s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = ready3 ? s2_valid_ff : s3_valid_ff;

   // Advancing beat takes its byte 0 from the fresh product; others read the
   // committed word. The previous advancing beat is at least eight beats ahead of a
   // continuing advance, so with three stages it has always committed before that one enters.
   always_comb begin
      ks_byte      = s2_adv_ff ? mix_word[7:0] : word_ff[{s2_pos_ff, 3'b000} +: 8];
      s3_result_in = s2_data_ff ^ ks_byte;
      word_in      = word_ff;
      if (s2_valid_ff && s2_adv_ff && ready3) begin
         word_in = mix_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         word_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         word_ff     <= word_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req.data_byte;
         s1_pos_ff  <= cur_pos;
         s1_adv_ff  <= (cur_pos == '0);
         s1_base_ff <= req.first_of_buffer ? cipher_key : word_ff;
      end
      if (ready2) begin
         s2_data_ff <= s1_data_ff;
         s2_pos_ff  <= s1_pos_ff;
         s2_adv_ff  <= s1_adv_ff;
      end
      if (ready3) begin
         s3_result_ff <= s3_result_in;
      end
   end

   assign rsp.valid       = s3_valid_ff;
   assign rsp.result_byte = s3_result_ff;

   // a first beat leaves the position at one
   a_first_pos : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.first_of_buffer) |=> (pos_ff == pos_type'(1)))
      else $error("position not restarted by first beat");

   // committed word moves only when an advancing beat leaves stage 2
   a_word_hold : assert property (@(posedge clock) disable iff (reset)
      !(s2_valid_ff && s2_adv_ff && ready3) |=> $stable(word_ff))
      else $error("keystream word changed without an advance");

   // no advance still in flight when a continuing advance reads the word
   a_no_hazard : assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req.first_of_buffer && (pos_ff == '0))
         |-> (!(s1_valid_ff && s1_adv_ff) && !(s2_valid_ff && s2_adv_ff)))
      else $error("advance base read before previous word committed");

endmodule

### sv/xkbc_csr.sv
module xkbc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [xkbc_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [xkbc_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [xkbc_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                   csr_pready,
   output xkbc_pkg::word_type                     cipher_key
);
   import xkbc_pkg::*;

   word_type key_ff;
   word_type key_in;
   logic     reg_idx;
   logic     wr_en;

   // register index is the 8-byte slot number
   assign reg_idx = csr_paddr[CsrAddrWidth-1];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_in = key_ff;
      if (wr_en && (reg_idx == CsrIdxKey)) begin
         key_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         CsrIdxKey: csr_prdata = key_ff;
         default:   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cipher_key = key_ff;

endmodule

### sv/xkbc_mix.sv
module xkbc_mix (
   input  logic               clock,
   input  logic               load,
   input  xkbc_pkg::word_type base_word,
   output xkbc_pkg::word_type next_word
);
   import xkbc_pkg::*;

   localparam logic [31:0] MultLo = MixMult[31:0];
   localparam logic [31:0] MultHi = MixMult[63:32];

   word_type    shuffled;
   logic [63:0] lo_ff,  lo_in;
   logic [31:0] crs_a_ff, crs_a_in;
   logic [31:0] crs_b_ff, crs_b_in;

   // x * M mod 2^64 = xl*Ml + ((xh*Ml + xl*Mh) mod 2^32) << 32
   always_comb begin
      shuffled = xorshift(base_word);
      lo_in    = 64'(shuffled[31:0]) * 64'(MultLo);
      crs_a_in = 32'(shuffled[63:32] * MultLo);
      crs_b_in = 32'(shuffled[31:0] * MultHi);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff    <= lo_in;
         crs_a_ff <= crs_a_in;
         crs_b_ff <= crs_b_in;
      end
   end

   assign next_word = lo_ff + {32'(crs_a_ff + crs_b_ff), 32'h0};

endmodule

### verif/tb_xorshift_keystream_byte_cipher_unit.sv
`timescale 1ns / 1ps

module tb_xorshift_keystream_byte_cipher_unit;
   import xkbc_pkg::*;

   // keystream constants for the predictor
   localparam word_type KsMult = 64'h2545_F491_4F6C_DD1D;
   localparam int unsigned KsShiftA = 12;
   localparam int unsigned KsShiftB = 25;
   localparam int unsigned KsShiftC = 27;

   // register map: one 64-bit register per 8-byte slot, only slot 0 is backed
   localparam logic [CsrAddrWidth-1:0] KeyAddr   = {CsrIdxKey, 3'b000};
   localparam logic [CsrAddrWidth-1:0] SpareAddr = {~CsrIdxKey, 3'b000};

   localparam int QuietLimit  = 500; // cycles with no beat at all
   localparam int DrainCycles = 4;   // three-stage pipe plus margin
   localparam int LongHold    = 60;
   localparam int PhaseBytes  = 320;

   typedef struct packed {
      byte_type data;
      logic     first;
   } byte_beat_type;

   logic clock;
   logic reset;

   xkbc_req_if req_bus ();
   xkbc_rsp_if rsp_bus ();

   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   xorshift_keystream_byte_cipher_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bytes waiting to be offered, and cipher bytes still owed by the block
   byte_beat_type plain_q[$];
   byte_type      cipher_out_q[$];

   // shadow of the key register and of the keystream state
   word_type key_shadow;
   word_type ks_word;
   pos_type  ks_pos;

   int mismatches;
   int req_wait;      // idle cycles left before the next request beat
   int req_streak;    // beats left in a run with no request gaps
   int rsp_stall;     // cycles left with ready low after a response beat
   int rsp_streak;
   int hold_left;     // long receiver hold-off, counted by the monitor
   int hold_off_req;  // set by the stimulus to start a hold-off
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   // xorshift(12,25,27) then multiply; the product is the new word
   function automatic word_type ks_advance(input word_type w);
      word_type x;
      x = w;
      x = x ^ (x >> KsShiftA);
      x = x ^ (x << KsShiftB);
      x = x ^ (x >> KsShiftC);
      return x * KsMult;
   endfunction

   // expected cipher byte for one accepted beat; moves the shadow state on
   function automatic byte_type keystream_xor(input byte_beat_type b);
      byte_type k;
      if (b.first) begin
         ks_word = key_shadow;
         ks_pos  = '0;
      end
      if (ks_pos == '0)
         ks_word = ks_advance(ks_word);
      k = ks_word[{ks_pos, 3'b000} +: 8];
      ks_pos = ks_pos + pos_type'(1);   // wraps modulo 8
      return b.data ^ k;
   endfunction

   function automatic int draw_gap(ref int streak);
      if (streak != 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         streak = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   // ---------------------------------------------------------------
   // request driver: offers plain_q[0], predicts on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_wait = 0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            cipher_out_q.push_back(keystream_xor(plain_q[0]));
            plain_q.pop_front();
            offer = 1'b0;
            req_wait = draw_gap(req_streak);
         end
         if (!offer) begin
            if (req_wait != 0) begin
               req_wait--;
            end else if (plain_q.size() != 0) begin
               offer = 1'b1;
               req_bus.data_byte       <= plain_q[0].data;
               req_bus.first_of_buffer <= plain_q[0].first;
            end
         end
         req_bus.valid <= offer;
      end
   end

   // ---------------------------------------------------------------
   // response monitor: checks each beat against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      byte_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (cipher_out_q.size() == 0) begin
               flag_mismatch($sformatf("result %h with nothing pending",
                                       rsp_bus.result_byte));
            end else begin
               want = cipher_out_q.pop_front();
               if (rsp_bus.result_byte !== want)
                  flag_mismatch($sformatf("result_byte %h, expected %h",
                                          rsp_bus.result_byte, want));
            end
            rsp_stall = draw_gap(rsp_streak);
         end else if (rsp_stall != 0) begin
            rsp_stall--;
         end
         if (hold_off_req != 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_bus.ready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   // watchdog: any beat on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("TIMEOUT: no beat for %0d cycles", QuietLimit);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one APB transfer: setup, then access until pready
   task automatic csr_access(input logic wr, input logic [CsrAddrWidth-1:0] addr,
                             input word_type wdata, output word_type rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write a register, then read the key back to check it (and that a spare
   // slot write left it alone)
   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr, input word_type value);
      word_type rd;
      csr_access(1'b1, addr, value, rd);
      if (addr == KeyAddr)
         key_shadow = value;
      csr_access(1'b0, KeyAddr, '0, rd);
      if (rd !== key_shadow)
         flag_mismatch($sformatf("key reads %h, expected %h", rd, key_shadow));
   endtask

   // pipe empty: nothing left to offer, nothing owed
   task automatic wait_idle();
      while (plain_q.size() != 0 || req_bus.valid || cipher_out_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic put_byte(input byte_type data, input logic first);
      byte_beat_type b;
      b.data  = data;
      b.first = first;
      plain_q.push_back(b);
   endtask

   task automatic queue_bytes(input int count, input logic mark);
      for (int i = 0; i < count; i++)
         put_byte(byte_type'($urandom), mark && (i == 0));
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      int       queued;
      int       len;
      word_type phase_key;

      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.data_byte       = '0;
      req_bus.first_of_buffer = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_psel                = 1'b0;
      csr_penable             = 1'b0;
      csr_pwrite              = 1'b0;
      csr_paddr               = '0;
      csr_pwdata              = '0;
      key_shadow              = '0;
      ks_word                 = '0;
      ks_pos                  = '0;
      mismatches              = 0;
      req_streak              = 0;
      rsp_streak              = 0;
      hold_left               = 0;
      hold_off_req            = 0;
      quiet_cycles            = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // no buffer started since reset: word is zero, bytes pass straight through
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'hA5, 1'b0);
      // buffer start with the reset key of zero keeps the word at zero
      put_byte(8'h5A, 1'b1);
      wait_idle();

      // all-ones key, nine bytes so the word advances twice, then a restart
      // while the position is part-way through a word
      csr_write(KeyAddr, '1);
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b0);
      queue_bytes(7, 1'b0);
      queue_bytes(3, 1'b1);
      wait_idle();

      // key changed mid-buffer: the running word carries on until the next
      // first mark; the spare slot must be ignored
      csr_write(KeyAddr, 64'h8000_0000_0000_0001);
      csr_write(SpareAddr, {$urandom, $urandom});
      queue_bytes(6, 1'b0);
      queue_bytes(2, 1'b1);
      wait_idle();

      // random phases, each with its own key
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       phase_key = '0;
            1:       phase_key = '1;
            2:       phase_key = 64'h0000_0000_0000_0001;
            default: phase_key = {$urandom, $urandom};
         endcase
         csr_write(KeyAddr, phase_key);
         if (ph == 3)
            csr_write(SpareAddr, {$urandom, $urandom});
         queued = 0;
         while (queued < PhaseBytes) begin
            // mostly short buffers; now and then a long one that wraps often
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 70)
                                                : $urandom_range(1, 20);
            // some runs continue the previous buffer without a first mark
            queue_bytes(len, $urandom_range(0, 6) != 0);
            queued += len;
         end
         // receiver goes quiet for a while so the pipe backs up into req
         if (ph == 1)
            hold_off_req = LongHold;
         wait_idle();
      end

      if (mismatches == 0 && cipher_out_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
